/* sv/message_packet_framer_top_defines.svh */
// Assertion macros for the framer's checker file.
// Depends on nothing; a user of these macros provides clk_i and rst_ni.
`ifndef MESSAGE_PACKET_FRAMER_TOP_DEFINES_SVH
`define MESSAGE_PACKET_FRAMER_TOP_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define MPF_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the default clk_i and rst_ni.
`define MPF_ASSERT(lbl, prop, msg) \
  `MPF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* sv/mpf_pkg.sv */
// Shared types, constants and helper functions of the message packet framer.
// Depends on nothing; every framer module refers to it by scoped names.
package mpf_pkg;

  localparam int DATA_PER_PACKET = 18;
  localparam int HEADER_BYTES    = 7;
  localparam int MAX_PACKETS     = 99;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 11;
  localparam int PKT_W  = 7;
  localparam int SLOT_W = $clog2(DATA_PER_PACKET + 1);

  localparam int MAX_LEN = MAX_PACKETS * DATA_PER_PACKET;

  // Packet count is ceil(len / DATA_PER_PACKET), done as a reciprocal multiply.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + DATA_PER_PACKET - 1) / DATA_PER_PACKET;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int NUM_W       = LEN_W + 1;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

  // One classified item as the front hands it to the back.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] first;
    logic [PKT_W-1:0]  total;
    logic [PKT_W-1:0]  pkt;
    logic              hdr;
    logic              eop;
    logic              eom;
  } mpf_desc_t;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } mpf_digits_t;

  // Decimal digits of a value below 128 (the value is taken modulo 1000).
  function automatic mpf_digits_t to_digits(input logic [PKT_W-1:0] v);
    logic              h;
    logic [PKT_W-1:0]  r;
    logic [14:0]       prod;
    logic [3:0]        t;
    logic [PKT_W-1:0]  o;
    mpf_digits_t       d;
    h    = (v >= PKT_W'(100));
    r    = h ? PKT_W'(v - PKT_W'(100)) : v;
    prod = 15'(r) * 15'd205;
    t    = prod[14:11];
    o    = PKT_W'(r - PKT_W'(t) * PKT_W'(10));
    d.hund = {3'b000, h};
    d.tens = t;
    d.ones = o[3:0];
    return d;
  endfunction

endpackage

/* sv/mpf_queue.sv */
// Short descriptor queue between the framer's front and back parts.
// Depends on mpf_pkg for the descriptor type and the queue depth.
module mpf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mpf_pkg::mpf_desc_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output mpf_pkg::mpf_desc_t head_o
);

  mpf_pkg::mpf_desc_t               mem_q [mpf_pkg::QUEUE_DEPTH];
  logic [mpf_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [mpf_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [mpf_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o  = (count_q == mpf_pkg::QCNT_W'(mpf_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == mpf_pkg::QPTR_W'(mpf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == mpf_pkg::QPTR_W'(mpf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/mpf_front.sv */
// Front part of the framer: length register, packet count, and per-item
// classification into queue descriptors. Depends on mpf_pkg.
module mpf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [mpf_pkg::LEN_W-1:0]    cfg_message_length_i,
  input  logic                         in_valid_i,
  input  logic [mpf_pkg::BYTE_W-1:0]   in_data_byte_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output mpf_pkg::mpf_desc_t           push_data_o
);

  logic [mpf_pkg::LEN_W-1:0]  eff_len_q;
  logic [mpf_pkg::PKT_W-1:0]  total_q;
  logic [mpf_pkg::LEN_W-1:0]  len_sat;
  logic [mpf_pkg::NUM_W-1:0]  len_num;
  logic [mpf_pkg::PROD_W-1:0] len_prod;

  logic [mpf_pkg::LEN_W-1:0]  taken_q, taken_d, taken_inc;
  logic [mpf_pkg::SLOT_W-1:0] slot_q, slot_d, slot_inc;
  logic [mpf_pkg::PKT_W-1:0]  pkt_q, pkt_d;
  logic [mpf_pkg::BYTE_W-1:0] first_q, first_d;
  logic                       accept, eom, eop;

  // Effective length: zero counts as one, long messages saturate.
  always_comb begin
    if (cfg_message_length_i == '0) begin
      len_sat = mpf_pkg::LEN_W'(1);
    end else if (32'(cfg_message_length_i) > mpf_pkg::MAX_LEN) begin
      len_sat = mpf_pkg::LEN_W'(mpf_pkg::MAX_LEN);
    end else begin
      len_sat = cfg_message_length_i;
    end
    len_num  = mpf_pkg::NUM_W'(len_sat) + mpf_pkg::NUM_W'(mpf_pkg::DATA_PER_PACKET - 1);
    len_prod = mpf_pkg::PROD_W'(len_num) * mpf_pkg::PROD_W'(mpf_pkg::RECIP);
  end

  assign accept    = in_valid_i && !queue_full_i;
  assign taken_inc = taken_q + 1'b1;
  assign slot_inc  = slot_q + 1'b1;
  assign eom       = (taken_inc >= eff_len_q);
  assign eop       = eom || (32'(slot_inc) >= mpf_pkg::DATA_PER_PACKET);
  assign first_d   = (taken_q == '0) ? in_data_byte_i : first_q;

  always_comb begin
    taken_d = taken_inc;
    slot_d  = slot_inc;
    pkt_d   = pkt_q;
    if (eom) begin
      taken_d = '0;
      slot_d  = '0;
      pkt_d   = mpf_pkg::PKT_W'(1);
    end else if (eop) begin
      slot_d = '0;
      pkt_d  = pkt_q + 1'b1;
    end
  end

  assign push_o            = accept;
  assign push_data_o.data  = in_data_byte_i;
  assign push_data_o.first = first_d;
  assign push_data_o.total = total_q;
  assign push_data_o.pkt   = pkt_q;
  assign push_data_o.hdr   = (slot_q == '0);
  assign push_data_o.eop   = eop;
  assign push_data_o.eom   = eom;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_len_q <= mpf_pkg::LEN_W'(1);
      total_q   <= mpf_pkg::PKT_W'(1);
      taken_q   <= '0;
      slot_q    <= '0;
      pkt_q     <= mpf_pkg::PKT_W'(1);
      first_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        eff_len_q <= len_sat;
        total_q   <= len_prod[mpf_pkg::RECIP_SHIFT +: mpf_pkg::PKT_W];
      end
      if (accept) begin
        taken_q <= taken_d;
        slot_q  <= slot_d;
        pkt_q   <= pkt_d;
        first_q <= first_d;
      end
    end
  end

endmodule

/* sv/mpf_back.sv */
// Back part of the framer: expands each descriptor into its data result, preceded by header
// results when it opens a packet, through a registered output stage. Depends on mpf_pkg.
module mpf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  mpf_pkg::mpf_desc_t          q_head_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mpf_pkg::BYTE_W-1:0]  out_byte_o,
  output logic [mpf_pkg::PKT_W-1:0]   out_packet_number_o,
  output logic                        out_is_header_o,
  output logic                        out_end_of_packet_o,
  output logic                        out_end_of_message_o,
  output logic                        out_last_o
);

  // Position of a result within the up to eight results of one item.
  typedef enum logic [2:0] {
    POS_TOT_HUND,
    POS_TOT_TENS,
    POS_TOT_ONES,
    POS_FIRST,
    POS_PKT_HUND,
    POS_PKT_TENS,
    POS_PKT_ONES,
    POS_DATA
  } pos_e;

  pos_e                        seq_q, pos;
  logic                        out_valid_q;
  logic                        load, fire;
  mpf_pkg::mpf_digits_t        tot_dig, pkt_dig;
  logic [mpf_pkg::BYTE_W-1:0]  byte_d, byte_q;
  logic [mpf_pkg::PKT_W-1:0]   pkt_q;
  logic                        hdr_q, eop_q, eom_q, last_q;

  assign load    = !out_valid_q || !out_stall_i;
  assign fire    = load && q_valid_i;
  assign pos     = q_head_i.hdr ? seq_q : POS_DATA;
  assign q_pop_o = fire && (pos == POS_DATA);
  assign tot_dig = mpf_pkg::to_digits(q_head_i.total);
  assign pkt_dig = mpf_pkg::to_digits(q_head_i.pkt);

  always_comb begin
    unique case (pos)
      POS_TOT_HUND: byte_d = mpf_pkg::ASCII_ZERO + 8'(tot_dig.hund);
      POS_TOT_TENS: byte_d = mpf_pkg::ASCII_ZERO + 8'(tot_dig.tens);
      POS_TOT_ONES: byte_d = mpf_pkg::ASCII_ZERO + 8'(tot_dig.ones);
      POS_FIRST:    byte_d = q_head_i.first;
      POS_PKT_HUND: byte_d = mpf_pkg::ASCII_ZERO + 8'(pkt_dig.hund);
      POS_PKT_TENS: byte_d = mpf_pkg::ASCII_ZERO + 8'(pkt_dig.tens);
      POS_PKT_ONES: byte_d = mpf_pkg::ASCII_ZERO + 8'(pkt_dig.ones);
      default:      byte_d = q_head_i.data;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      seq_q       <= POS_TOT_HUND;
      byte_q      <= '0;
      pkt_q       <= '0;
      hdr_q       <= 1'b0;
      eop_q       <= 1'b0;
      eom_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= q_valid_i;
      end
      if (fire) begin
        seq_q  <= q_pop_o ? POS_TOT_HUND : pos_e'(seq_q + 3'd1);
        byte_q <= byte_d;
        pkt_q  <= q_head_i.pkt;
        hdr_q  <= (pos != POS_DATA);
        eop_q  <= (pos == POS_DATA) && q_head_i.eop;
        eom_q  <= (pos == POS_DATA) && q_head_i.eom;
        last_q <= (pos == POS_DATA);
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_byte_o           = byte_q;
  assign out_packet_number_o  = pkt_q;
  assign out_is_header_o      = hdr_q;
  assign out_end_of_packet_o  = eop_q;
  assign out_end_of_message_o = eom_q;
  assign out_last_o           = last_q;

endmodule

/* sv/message_packet_framer_top.sv */
// A byte passes the descriptor queue and then the output register before its first result is out.
// Throughput: one item per cycle at the input while the descriptor queue has room; the
// output register sends one result per cycle while out_stall_i is low, so a byte that opens
// a packet gives eight results and any other byte one.
// Reset (rst_ni, asynchronous, active low) empties the queue and output stage, sets the
// message length to one and restarts framing at packet one.
//
// Structure: the front part holds the length register and the packet count derived from
// it, tracks the position in the message and turns each accepted item into a descriptor.
// A two-entry queue decouples it from the back part, which expands each descriptor into
// its results. The length register may be written whenever the block is idle; a write
// takes effect for the next item, also in the middle of a message.
module message_packet_framer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel: the message length in data bytes.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mpf_pkg::LEN_W-1:0]   cfg_message_length_i,
  // Input channel: one message byte per item.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mpf_pkg::BYTE_W-1:0]  in_data_byte_i,
  // Output channel: one packet byte per item.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mpf_pkg::BYTE_W-1:0]  out_byte_o,
  output logic [mpf_pkg::PKT_W-1:0]   out_packet_number_o,
  output logic                        out_is_header_o,
  output logic                        out_end_of_packet_o,
  output logic                        out_end_of_message_o,
  output logic                        out_last_o
);

  logic               queue_full;
  logic               push;
  mpf_pkg::mpf_desc_t push_data;
  logic               q_valid;
  logic               q_pop;
  mpf_pkg::mpf_desc_t q_head;

  // The length register is a plain flop, so a write is always taken at once.
  assign cfg_ready_o = 1'b1;

  // Stall depends only on the registered queue fill level, never on in_valid_i.
  assign in_stall_o = queue_full;

  mpf_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_message_length_i (cfg_message_length_i),
    .in_valid_i           (in_valid_i),
    .in_data_byte_i       (in_data_byte_i),
    .queue_full_i         (queue_full),
    .push_o               (push),
    .push_data_o          (push_data)
  );

  mpf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // The back part owns the output register; a stalled result holds there while the
  // queue takes new descriptors from the front until it is full.
  mpf_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_valid_i            (q_valid),
    .q_head_i             (q_head),
    .q_pop_o              (q_pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_byte_o           (out_byte_o),
    .out_packet_number_o  (out_packet_number_o),
    .out_is_header_o      (out_is_header_o),
    .out_end_of_packet_o  (out_end_of_packet_o),
    .out_end_of_message_o (out_end_of_message_o),
    .out_last_o           (out_last_o)
  );

endmodule

/* sv/mpf_checker.sv */
// Port-level checker for the framer top level, attached by bind below.
// Depends on mpf_pkg and message_packet_framer_top_defines.svh.
`include "message_packet_framer_top_defines.svh"

module mpf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [mpf_pkg::BYTE_W-1:0]  out_byte_o,
  input logic [mpf_pkg::PKT_W-1:0]   out_packet_number_o,
  input logic                        out_is_header_o,
  input logic                        out_end_of_packet_o,
  input logic                        out_end_of_message_o,
  input logic                        out_last_o
);

  logic                                        hdr_end;
  logic                                        eom_seen;
  logic                                        out_hold;
  logic [mpf_pkg::BYTE_W+mpf_pkg::PKT_W+3:0]   out_item;

  assign hdr_end  = out_end_of_packet_o || out_end_of_message_o;
  assign eom_seen = out_valid_o && out_end_of_message_o;
  assign out_hold = out_valid_o && out_stall_i;
  assign out_item = {out_byte_o, out_packet_number_o, out_is_header_o, out_end_of_packet_o,
                     out_end_of_message_o, out_last_o};

  // Every data byte closes its item, and no header byte does.
  `MPF_ASSERT(a_last_hdr, out_valid_o |-> (out_last_o == !out_is_header_o), "last flag wrong")

  // Header bytes never carry end flags.
  `MPF_ASSERT(a_hdr_no_end, out_valid_o && out_is_header_o |-> !hdr_end, "header with end flag")

  // The end of the message always closes a packet.
  `MPF_ASSERT(a_eom_eop, eom_seen |-> out_end_of_packet_o, "message ends inside a packet")

  // Packets are numbered from one.
  `MPF_ASSERT(a_pkt_nonzero, out_valid_o |-> (out_packet_number_o != '0), "packet number zero")

  // A stalled result stays on the port unchanged.
  `MPF_ASSERT(a_out_hold, out_hold |=> out_valid_o && $stable(out_item), "stalled item changed")

endmodule

bind message_packet_framer_top mpf_checker u_mpf_checker (.*);
